FILE: hdl/ipow_pkg.sv
// Package for the signed 64-bit integer power pipeline.
// Holds the widths, the step count and the item carried between stages.
// No dependencies.
package ipow_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned STEPS  = 6;

  localparam logic [DATA_W-1:0] SIGN_MAG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [DATA_W-1:0] r;
    logic              r_ovf;
    logic [DATA_W-1:0] s;
    logic              s_ovf;
    logic [STEPS-1:0]  ebits;
    logic              neg;
    logic              spec;
    logic              spec_status;
    logic [DATA_W-1:0] spec_power;
  } ipow_item_t;

endpackage

FILE: hdl/ipow_in_if.sv
// Operand channel of the integer power block: valid, ready, base, exponent.
// Depends on nothing.
interface ipow_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] base;
  logic signed [63:0] exponent;

  modport source (output valid, base, exponent, input ready);
  modport sink (input valid, base, exponent, output ready);
endinterface

FILE: hdl/ipow_out_if.sv
// Result channel of the integer power block: valid, ready, power, status.
// Depends on nothing.
interface ipow_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] power;
  logic               status;

  modport source (output valid, power, status, input ready);
  modport sink (input valid, power, status, output ready);
endinterface

FILE: hdl/int64_power_with_overflow.sv
// Signed 64-bit integer power with a "needs float" status.
// Pipeline: decode stage, six square-and-multiply steps of two stages each,
// then an output register.
// Throughput: one beat per cycle; a stalled result holds the whole pipeline.
// Reset clears all valid bits; payload registers are not reset.
// Depends on ipow_pkg, ipow_in_if, ipow_out_if, ipow_step.
module int64_power_with_overflow #(
  parameter int unsigned MAX_EXPONENT = 62
) (
  input logic        clk,
  input logic        rst,
  ipow_in_if.sink    operands,
  ipow_out_if.source result
);

  localparam int unsigned DW = ipow_pkg::DATA_W;
  localparam int unsigned NS = ipow_pkg::STEPS;

  logic                 adv;
  logic                 b_neg;
  logic [DW-1:0]        mag;
  logic                 unit;
  logic                 zz;
  logic                 rng;
  ipow_pkg::ipow_item_t dec_next;

  logic                 dec_valid;
  ipow_pkg::ipow_item_t dec_item;

  logic [NS:0]          chain_valid;
  ipow_pkg::ipow_item_t chain_item [NS+1];

  ipow_pkg::ipow_item_t fin;
  logic                 fin_ovf;

  assign adv = !result.valid || result.ready;
  assign operands.ready = adv;

  always_comb begin
    b_neg = operands.base[DW-1];
    mag   = b_neg ? (DW'(0) - DW'(operands.base)) : DW'(operands.base);
    unit  = (mag == DW'(1));
    zz    = (operands.base == '0) && (operands.exponent == '0);
    rng   = operands.exponent[DW-1] || (DW'(operands.exponent) > DW'(MAX_EXPONENT));

    dec_next             = '0;
    dec_next.r           = DW'(1);
    dec_next.s           = mag;
    dec_next.ebits       = operands.exponent[NS-1:0];
    dec_next.neg         = b_neg & operands.exponent[0];
    dec_next.spec        = zz | unit | rng;
    dec_next.spec_status = zz | (!unit & rng);
    dec_next.spec_power  = (unit && operands.exponent[0]) ? DW'(operands.base) :
                           (unit ? DW'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (adv) begin
      dec_valid <= operands.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dec_item <= dec_next;
    end
  end

  assign chain_valid[0] = dec_valid;
  assign chain_item[0]  = dec_item;

  for (genvar k = 0; k < NS; k++) begin : g_step
    ipow_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (chain_valid[k]),
      .in_item   (chain_item[k]),
      .out_valid (chain_valid[k+1]),
      .out_item  (chain_item[k+1])
    );
  end

  always_comb begin
    fin     = chain_item[NS];
    fin_ovf = fin.r_ovf || (!fin.neg && fin.r[DW-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= chain_valid[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fin.spec) begin
        result.power  <= fin.spec_power;
        result.status <= fin.spec_status;
      end else if (fin_ovf) begin
        result.power  <= '0;
        result.status <= 1'b1;
      end else begin
        result.power  <= fin.neg ? (DW'(0) - fin.r) : fin.r;
        result.status <= 1'b0;
      end
    end
  end

  a_status_zero : assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status |-> result.power == '0)
    else $error("status set with nonzero power");

  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(chain_valid) && $stable(dec_valid))
    else $error("pipeline moved during stall");

endmodule

FILE: hdl/ipow_step.sv
// One exponent bit of square-and-multiply: two register stages that form
// r*s (when the bit is set) and s*s with sticky overflow flags.
// Depends on ipow_pkg.
module ipow_step (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  ipow_pkg::ipow_item_t  in_item,
  output logic                  out_valid,
  output ipow_pkg::ipow_item_t  out_item
);

  localparam int unsigned DW = ipow_pkg::DATA_W;
  localparam int unsigned HW = ipow_pkg::HALF_W;

  logic [1:0][DW-1:0]   op_a;
  logic [1:0][DW-1:0]   op_b;
  logic [1:0][HW-1:0]   op_x;
  logic [1:0][DW-1:0]   op_y;
  logic [1:0][DW-1:0]   pl_next;
  logic [1:0][DW-1:0]   ph_next;
  logic [1:0]           both_next;

  logic                 a_valid;
  ipow_pkg::ipow_item_t a_item;
  logic [1:0][DW-1:0]   pl;
  logic [1:0][DW-1:0]   ph;
  logic [1:0]           both;

  logic [1:0][DW+HW-1:0] prod;
  logic [1:0]            ovf;
  ipow_pkg::ipow_item_t  item_next;

  // lane 0: r*s, lane 1: s*s
  always_comb begin
    op_a[0] = in_item.r;
    op_b[0] = in_item.s;
    op_a[1] = in_item.s;
    op_b[1] = in_item.s;
    for (int l = 0; l < 2; l++) begin
      both_next[l] = (|op_a[l][DW-1:HW]) && (|op_b[l][DW-1:HW]);
      op_x[l] = (|op_a[l][DW-1:HW]) ? op_b[l][HW-1:0] : op_a[l][HW-1:0];
      op_y[l] = (|op_a[l][DW-1:HW]) ? op_a[l] : op_b[l];
      pl_next[l] = DW'(op_x[l]) * DW'(op_y[l][HW-1:0]);
      ph_next[l] = DW'(op_x[l]) * DW'(op_y[l][DW-1:HW]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item <= in_item;
      pl     <= pl_next;
      ph     <= ph_next;
      both   <= both_next;
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      prod[l] = {{HW{1'b0}}, pl[l]} + {ph[l], {HW{1'b0}}};
      ovf[l]  = both[l] || (|prod[l][DW+HW-1:DW]) ||
                (prod[l][DW-1] && (|prod[l][DW-2:0]));
    end
    item_next = a_item;
    if (a_item.ebits[0]) begin
      item_next.r     = prod[0][DW-1:0];
      item_next.r_ovf = a_item.r_ovf | a_item.s_ovf | ovf[0];
    end
    item_next.s     = prod[1][DW-1:0];
    item_next.s_ovf = a_item.s_ovf | ovf[1];
    item_next.ebits = a_item.ebits >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule
